/* rtl/fec23_pkg.sv */
`timescale 1ns / 1ps

package fec23_pkg;

  localparam int DATA_BITS = 10;
  localparam int PAR_BITS  = 5;
  localparam int CW_BITS   = DATA_BITS + PAR_BITS;
  localparam int BYTE_BITS = 8;
  localparam int DACC_W    = 17;
  localparam int CACC_W    = 22;
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0] BLOCK_LEN = 5'd10;
  localparam logic [CNT_W-1:0] CW_LEN    = 5'd15;
  localparam logic [CNT_W-1:0] BYTE_LEN  = 5'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [CW_BITS-1:0] cw;
    logic               last;
  } cw_entry_t;

  function automatic logic [PAR_BITS-1:0] calc_parity(input logic [DATA_BITS-1:0] d);
    logic [PAR_BITS-1:0] s;
    logic                fb;
    s = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      fb = d[i] ^ s[0];
      s  = {fb, s[PAR_BITS-1:1] ^ {1'b0, fb, 1'b0, fb}};
    end
    return s;
  endfunction

  function automatic logic [CW_BITS-1:0] make_cw(input logic [DATA_BITS-1:0] d);
    return {calc_parity(d), d};
  endfunction

endpackage

/* rtl/fec_2_3_hamming_15_10_stream_encoder_core.sv */
`timescale 1ns / 1ps

// Channel   Ports                          Accepted when
// input     push, full, in_item            push && !full
// result    pop, empty, out_item           pop && !empty
//
// The front stage takes one byte per cycle while full is low and forms at most one
// codeword, or two on a final byte, which raises full until the second is queued.
// While pop keeps the result taken, the back stage emits one output byte per cycle
// from its 22-bit bit accumulator; the sustained input rate is two thirds of that.
// A result passes through the codeword queue and the back stage's output register.
// Reset is synchronous and active low and clears all accumulators and queues.
// Either side may stall independently; the codeword queue absorbs the difference.

module fec_2_3_hamming_15_10_stream_encoder_core import fec23_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic      q_wr;
  cw_entry_t q_wdata;
  logic      q_full;
  logic      q_rd;
  logic      q_valid;
  cw_entry_t q_rdata;

  fec23_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  fec23_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  fec23_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

/* rtl/fec23_front.sv */
`timescale 1ns / 1ps

module fec23_front import fec23_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      q_wr,
  output cw_entry_t q_wdata,
  input  logic      q_full
);

  logic [DACC_W-1:0] dacc_r, dacc_nxt;
  logic [CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  cw_entry_t         pend_r, pend_nxt;

  logic              accept;
  logic [DACC_W-1:0] merged;
  logic [DACC_W-1:0] rem_acc;
  logic [CNT_W-1:0]  mcnt;
  logic [CNT_W-1:0]  rem_cnt;
  logic              have_block;
  logic              two_cw;
  cw_entry_t         first_entry;

  assign full   = pend_valid_r || q_full;
  assign accept = push && !full;

  always_comb begin
    merged      = dacc_r | ({{(DACC_W-BYTE_BITS){1'b0}}, in_item.in_byte} << dcnt_r);
    mcnt        = dcnt_r + BYTE_LEN;
    have_block  = mcnt >= BLOCK_LEN;
    rem_acc     = merged >> DATA_BITS;
    rem_cnt     = mcnt - BLOCK_LEN;
    two_cw      = in_item.in_last && have_block && (rem_cnt != '0);
    first_entry = '{cw: make_cw(merged[DATA_BITS-1:0]), last: in_item.in_last && !two_cw};
  end

  always_comb begin
    dacc_nxt       = dacc_r;
    dcnt_nxt       = dcnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    if (accept) begin
      if (in_item.in_last) begin
        dacc_nxt = '0;
        dcnt_nxt = '0;
      end else if (have_block) begin
        dacc_nxt = rem_acc;
        dcnt_nxt = rem_cnt;
      end else begin
        dacc_nxt = merged;
        dcnt_nxt = mcnt;
      end
      if (two_cw) begin
        pend_valid_nxt = 1'b1;
        pend_nxt       = '{cw: make_cw(rem_acc[DATA_BITS-1:0]), last: 1'b1};
      end
    end else if (pend_valid_r && !q_full) begin
      pend_valid_nxt = 1'b0;
    end
  end

  assign q_wr    = (accept && (have_block || in_item.in_last)) || (pend_valid_r && !q_full);
  assign q_wdata = pend_valid_r ? pend_r : first_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dacc_r       <= '0;
      dcnt_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      dacc_r       <= dacc_nxt;
      dcnt_r       <= dcnt_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

/* rtl/fec23_fifo.sv */
`timescale 1ns / 1ps

module fec23_fifo import fec23_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  cw_entry_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output logic      rd_valid,
  output cw_entry_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  cw_entry_t         mem_r [DEPTH];
  cw_entry_t         rd_data_r;
  logic [PW-1:0]     wptr_r, wptr_nxt;
  logic [PW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full     = cnt_r == DEPTH_C;
  assign rd_valid = cnt_r != '0;
  assign rd_data  = rd_data_r;
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  // The head item is fetched ahead; an item written straight into the head slot bypasses the array.
  always_ff @(posedge clk) begin
    if (do_wr && (wptr_r == rptr_nxt)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[rptr_nxt];
    end
  end

endmodule

/* rtl/fec23_back.sv */
`timescale 1ns / 1ps

module fec23_back import fec23_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cw_entry_t q_rdata,
  output logic      q_rd,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic [CACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              plast_r, plast_nxt;
  logic              ovalid_r, ovalid_nxt;
  out_item_t         oitem_r, oitem_nxt;

  logic              can_emit;
  logic              take;
  logic [CACC_W-1:0] v_acc;
  logic [CNT_W-1:0]  v_cnt;
  logic              v_last;
  logic              emit;

  assign can_emit = !ovalid_r || pop;
  assign take     = q_valid && (cnt_r < BYTE_LEN) && !plast_r && can_emit;

  always_comb begin
    if (take) begin
      v_acc  = acc_r | ({{(CACC_W-CW_BITS){1'b0}}, q_rdata.cw} << cnt_r);
      v_cnt  = cnt_r + CW_LEN;
      v_last = q_rdata.last;
    end else begin
      v_acc  = acc_r;
      v_cnt  = cnt_r;
      v_last = plast_r;
    end
    emit = ((v_cnt >= BYTE_LEN) || (v_last && (v_cnt != '0))) && can_emit;
  end

  always_comb begin
    acc_nxt    = v_acc;
    cnt_nxt    = v_cnt;
    plast_nxt  = v_last;
    ovalid_nxt = ovalid_r && !pop;
    oitem_nxt  = oitem_r;
    if (emit) begin
      acc_nxt    = v_acc >> BYTE_BITS;
      cnt_nxt    = (v_cnt >= BYTE_LEN) ? v_cnt - BYTE_LEN : '0;
      plast_nxt  = v_last && (v_cnt > BYTE_LEN);
      ovalid_nxt = 1'b1;
      oitem_nxt  = '{out_byte: v_acc[BYTE_BITS-1:0], out_last: v_last && (v_cnt <= BYTE_LEN)};
    end
  end

  assign q_rd     = take;
  assign empty    = !ovalid_r;
  assign out_item = oitem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      plast_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      plast_r  <= plast_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oitem_r <= oitem_nxt;
  end

endmodule

/* rtl/fec23_checker.sv */
`timescale 1ns / 1ps

module fec23_checker import fec23_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  // A held result must not change while it waits.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("block not idle after reset");

  // When the input is blocked, queued work exists and must reach an empty output.
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    full && empty |=> !empty)
    else $error("output idle while input is blocked");

endmodule

bind fec_2_3_hamming_15_10_stream_encoder_core fec23_checker u_chk (.*);
